### hw/rtl/sma_pkg.sv
package sma_pkg;

    localparam int PRICE_W = 31;
    localparam int LEN_W = 7;
    localparam int TREND_W = 2;
    localparam logic [LEN_W-1:0] RESET_LENGTH = 7'd5;

    typedef enum logic [TREND_W-1:0] {
        TREND_UNKNOWN = 2'd0,
        TREND_UP      = 2'd1,
        TREND_DOWN    = 2'd2
    } trend_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

### hw/rtl/sma_ram.sv
module sma_ram #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 31
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sma_div.sv
module sma_div #(
    parameter int SUM_W = 37
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sma_pkg::div_ctrl_t        ctrl,
    input  logic [SUM_W-1:0]          dividend,
    input  logic [sma_pkg::LEN_W-1:0] divisor,
    output sma_pkg::div_stat_t        stat,
    output logic [SUM_W-1:0]          quotient
);

    import sma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [LEN_W:0]   trial;
    logic             fits;
    logic [LEN_W:0]   diff;

    // Restoring division: one quotient bit per cycle, the dividend shifting
    // out of the top of the quotient register as quotient bits enter below.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !ctrl.start && (count_reg == CNT_W'(1));
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(SUM_W);
                quo_reg   <= dividend;
                rem_reg   <= '0;
            end
            else if (busy_reg)
            begin
                quo_reg   <= {quo_reg[SUM_W-2:0], fits};
                rem_reg   <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### hw/rtl/simple_moving_average_trend.sv
// Simple moving average with trend. Each transfer on the input channel
// carries one closing price; each produces exactly one result transfer with
// average_valid, the truncated mean of the last window_length prices
// (zero until the window has filled) and a trend of unknown, up or down
// against the previous average (equal averages count as down). A full
// window's mean comes from the bit-serial restoring divider, which yields
// one quotient bit a cycle over the SUM_W-bit running sum, 37 bits with
// the default WINDOW_MAX of 64; prices that leave the average invalid
// skip the divider. The next price is taken once the block is back in
// idle, which it enters as the result is offered, even while the last
// result still waits at the output. Writing window_length empties the window
// and clears the trend history; a value of 0 acts as 1 and one above
// WINDOW_MAX acts as WINDOW_MAX. The price ring sits in a memory of
// WINDOW_MAX entries.
module simple_moving_average_trend #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sma_pkg::PRICE_W-1:0] close_price,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        average_valid,
    output logic [sma_pkg::PRICE_W-1:0] average_price,
    output logic [sma_pkg::TREND_W-1:0] trend,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sma_pkg::LEN_W-1:0]   window_length
);

    import sma_pkg::*;

    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W   = PRICE_W + PTR_W;
    localparam int LEN_CAP = (WINDOW_MAX > 127) ? 127 : WINDOW_MAX;
    localparam int CMP_W   = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [LEN_W-1:0]   fill_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   slot_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [PRICE_W-1:0] avg_reg;
    logic               valid_reg;
    logic [PRICE_W-1:0] prev_avg_reg;
    logic               prev_valid_reg;
    logic               out_valid_reg;
    logic               average_valid_reg;
    logic [PRICE_W-1:0] average_price_reg;
    trend_t             trend_reg;

    logic [LEN_W-1:0]   len_eff;
    logic [PTR_W-1:0]   slot_next;
    logic [PTR_W-1:0]   ptr_next;
    logic [CMP_W-1:0]   slot_inc;
    logic               full;
    logic               in_accept;
    logic               cfg_accept;
    logic               out_free;
    logic               result_load;
    trend_t             trend_calc;

    logic [PRICE_W-1:0] old_price;
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [SUM_W-1:0]   quotient;

    always_comb
    begin
        priority if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(length_reg) > LEN_CAP)
        begin
            len_eff = LEN_W'(LEN_CAP);
        end
        else
        begin
            len_eff = length_reg;
        end
    end

    // A pointer left beyond a shorter window wraps back to the first slot.
    assign slot_next = (CMP_W'(ptr_reg) >= CMP_W'(len_eff)) ? '0 : ptr_reg;
    assign slot_inc  = CMP_W'(slot_reg) + CMP_W'(1);
    assign ptr_next  = (slot_inc >= CMP_W'(len_eff)) ? '0 : slot_inc[PTR_W-1:0];
    assign full      = fill_reg >= len_eff;

    assign cfg_ready   = (state_reg == ST_IDLE);
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign in_stall    = (state_reg != ST_IDLE) || cfg_valid;
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign result_load = (state_reg == ST_DONE) && out_free;

    assign div_ctrl.start = (state_reg == ST_CHECK) && full;

    always_comb
    begin
        if (valid_reg && prev_valid_reg)
        begin
            trend_calc = (avg_reg > prev_avg_reg) ? TREND_UP : TREND_DOWN;
        end
        else
        begin
            trend_calc = TREND_UNKNOWN;
        end
    end

    sma_ram #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (PTR_W),
        .DATA_W (PRICE_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_ADD),
        .wr_addr (slot_reg),
        .wr_data (price_reg),
        .rd_en   (in_accept),
        .rd_addr (slot_next),
        .rd_data (old_price)
    );

    sma_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (len_eff),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            length_reg        <= RESET_LENGTH;
            sum_reg           <= '0;
            fill_reg          <= '0;
            ptr_reg           <= '0;
            prev_avg_reg      <= '0;
            prev_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            valid_reg         <= 1'b0;
            average_valid_reg <= 1'b0;
            average_price_reg <= '0;
            trend_reg         <= TREND_UNKNOWN;
        end
        else
        begin
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_accept)
                    begin
                        length_reg     <= window_length;
                        sum_reg        <= '0;
                        fill_reg       <= '0;
                        ptr_reg        <= '0;
                        prev_avg_reg   <= '0;
                        prev_valid_reg <= 1'b0;
                    end
                    else if (in_accept)
                    begin
                        price_reg <= close_price;
                        slot_reg  <= slot_next;
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB:
                begin
                    // The oldest price leaves the sum only once the window is full.
                    if (full)
                    begin
                        sum_reg <= sum_reg - SUM_W'(old_price);
                    end
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    sum_reg <= sum_reg + SUM_W'(price_reg);
                    if (!full)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    ptr_reg   <= ptr_next;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    valid_reg <= full;
                    avg_reg   <= '0;
                    state_reg <= full ? ST_DIV : ST_DONE;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        avg_reg   <= quotient[PRICE_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        average_valid_reg <= valid_reg;
                        average_price_reg <= avg_reg;
                        trend_reg         <= trend_calc;
                        prev_avg_reg      <= avg_reg;
                        prev_valid_reg    <= valid_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_valid = average_valid_reg;
    assign average_price = average_price_reg;
    assign trend         = trend_reg;

endmodule
